>>> design/aging_peer_presence_table_defines.svh
// assertion macros for the aging peer presence table
// used by appt_datapath, which checks its own logic; no other dependencies
`ifndef AGING_PEER_PRESENCE_TABLE_DEFINES_SVH
`define AGING_PEER_PRESENCE_TABLE_DEFINES_SVH

// condition holds at every edge out of reset, clocked by aclk
`define APPT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequence holds in the same cycle as the antecedent
`define APPT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/appt_pkg.sv
// shared types, codes and sizes of the aging peer presence table
// no dependencies
package appt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int TIMER_W     = 16;
    localparam int ENTRY_W     = 5;
    localparam int REQ_W       = 2;
    localparam int CODE_W      = 3;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [TIMER_W-1:0] timer_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [REQ_W-1:0]   req_t;
    typedef logic [CODE_W-1:0]  code_t;

    localparam timer_t TIMEOUT_RESET = 16'd9000;

    localparam req_t REQ_HEARD  = 2'd0;
    localparam req_t REQ_REMOVE = 2'd1;
    localparam req_t REQ_TICK   = 2'd2;
    localparam req_t REQ_NONE   = 2'd3;

    localparam code_t EV_ADDED     = 3'd0;
    localparam code_t EV_REFRESHED = 3'd1;
    localparam code_t EV_TIMED_OUT = 3'd2;
    localparam code_t EV_REMOVED   = 3'd3;
    localparam code_t EV_NOT_FOUND = 3'd4;
    localparam code_t EV_FULL      = 3'd5;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_none;
        logic scan_done;
        logic step_blocked;
        logic finish_blocked;
    } ctrl_status_t;

endpackage

>>> design/appt_datapath.sv
// table storage, scan pointers, pending expiry and output register
// depends on appt_pkg and aging_peer_presence_table_defines.svh
`include "aging_peer_presence_table_defines.svh"

module appt_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  appt_pkg::ctrl_cmd_t    cmd,
    output appt_pkg::ctrl_status_t status,
    input  appt_pkg::req_t         req_type,
    input  appt_pkg::addr_t        peer_address,
    input  logic                   cfg_valid,
    input  appt_pkg::timer_t       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output appt_pkg::code_t        out_event_code,
    output appt_pkg::addr_t        out_event_address,
    output appt_pkg::entry_t       out_entry_count,
    output logic                   out_last
);

    appt_pkg::addr_t  addr_mem [appt_pkg::TABLE_DEPTH];
    appt_pkg::timer_t cnt_mem  [appt_pkg::TABLE_DEPTH];

    appt_pkg::addr_t  rd_addr_reg;
    appt_pkg::timer_t rd_cnt_reg;

    appt_pkg::timer_t timeout_reg;
    appt_pkg::req_t   req_reg;
    appt_pkg::addr_t  key_reg;
    logic             found_reg;
    appt_pkg::cnt_t   idx_reg;
    appt_pkg::cnt_t   wr_ptr_reg;
    appt_pkg::cnt_t   len_reg;
    appt_pkg::cnt_t   count_reg;
    logic             pend_valid_reg;
    appt_pkg::addr_t  pend_addr_reg;
    appt_pkg::cnt_t   pend_count_reg;

    logic             out_valid_reg;
    appt_pkg::code_t  out_code_reg;
    appt_pkg::addr_t  out_addr_reg;
    appt_pkg::entry_t out_count_reg;
    logic             out_last_reg;

    logic             is_tick;
    logic             is_heard;
    logic             is_remove;
    logic             match;
    logic             expire;
    logic             keep;
    logic             out_free;
    logic             step_emits;

    logic             mem_we;
    appt_pkg::idx_t   mem_waddr;
    appt_pkg::addr_t  mem_wdata_addr;
    appt_pkg::timer_t mem_wdata_cnt;
    appt_pkg::idx_t   mem_raddr;
    appt_pkg::cnt_t   next_idx;

    logic             push;
    appt_pkg::code_t  push_code;
    appt_pkg::addr_t  push_addr;
    appt_pkg::cnt_t   push_count;
    logic             push_last;

    assign is_tick    = (req_reg == appt_pkg::REQ_TICK);
    assign is_heard   = (req_reg == appt_pkg::REQ_HEARD);
    assign is_remove  = (req_reg == appt_pkg::REQ_REMOVE);
    assign match      = (rd_addr_reg == key_reg) && !found_reg;
    assign expire     = (rd_cnt_reg <= appt_pkg::timer_t'(1));
    assign step_emits = is_tick && expire;
    assign keep       = !step_emits && !(is_remove && match);
    assign out_free   = !out_valid_reg || out_ready;
    assign next_idx   = idx_reg + appt_pkg::cnt_t'(1);

    assign status.req_none       = (req_type == appt_pkg::REQ_NONE);
    assign status.scan_done      = (idx_reg == len_reg);
    assign status.step_blocked   = step_emits && pend_valid_reg && !out_free;
    assign status.finish_blocked = (!is_tick || pend_valid_reg) && !out_free;

    // memory port selection
    always_comb begin
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg[appt_pkg::IDX_W-1:0];
        mem_wdata_addr = rd_addr_reg;
        mem_wdata_cnt  = rd_cnt_reg;
        if (is_heard && match) begin
            mem_wdata_cnt = timeout_reg;
        end else if (is_tick) begin
            mem_wdata_cnt = rd_cnt_reg - appt_pkg::timer_t'(1);
        end
        if (cmd.step) begin
            mem_we = keep;
        end else if (cmd.finish && is_heard && !found_reg
                     && (count_reg < appt_pkg::cnt_t'(appt_pkg::TABLE_DEPTH))) begin
            mem_we         = 1'b1;
            mem_waddr      = count_reg[appt_pkg::IDX_W-1:0];
            mem_wdata_addr = key_reg;
            mem_wdata_cnt  = timeout_reg;
        end
        if (cmd.start) begin
            mem_raddr = '0;
        end else if (cmd.step) begin
            mem_raddr = next_idx[appt_pkg::IDX_W-1:0];
        end else begin
            mem_raddr = idx_reg[appt_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            addr_mem[mem_waddr] <= mem_wdata_addr;
            cnt_mem[mem_waddr]  <= mem_wdata_cnt;
        end
        rd_addr_reg <= addr_mem[mem_raddr];
        rd_cnt_reg  <= cnt_mem[mem_raddr];
    end

    // result selection
    always_comb begin
        push       = 1'b0;
        push_code  = appt_pkg::EV_TIMED_OUT;
        push_addr  = pend_addr_reg;
        push_count = pend_count_reg;
        push_last  = 1'b0;
        if (cmd.step && step_emits && pend_valid_reg) begin
            push = 1'b1;
        end else if (cmd.finish) begin
            push_last = 1'b1;
            push_addr = key_reg;
            unique case (req_reg)
                appt_pkg::REQ_HEARD: begin
                    push = 1'b1;
                    if (found_reg) begin
                        push_code  = appt_pkg::EV_REFRESHED;
                        push_count = count_reg;
                    end else if (count_reg >= appt_pkg::cnt_t'(appt_pkg::TABLE_DEPTH)) begin
                        push_code  = appt_pkg::EV_FULL;
                        push_count = count_reg;
                    end else begin
                        push_code  = appt_pkg::EV_ADDED;
                        push_count = count_reg + appt_pkg::cnt_t'(1);
                    end
                end
                appt_pkg::REQ_REMOVE: begin
                    push       = 1'b1;
                    push_code  = found_reg ? appt_pkg::EV_REMOVED : appt_pkg::EV_NOT_FOUND;
                    push_count = count_reg;
                end
                appt_pkg::REQ_TICK: begin
                    push      = pend_valid_reg;
                    push_addr = pend_addr_reg;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= appt_pkg::TIMEOUT_RESET;
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_ptr_reg     <= '0;
            len_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            req_reg        <= appt_pkg::REQ_NONE;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            if (cmd.start) begin
                req_reg        <= req_type;
                key_reg        <= peer_address;
                idx_reg        <= '0;
                wr_ptr_reg     <= '0;
                len_reg        <= count_reg;
                found_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.step) begin
                idx_reg <= next_idx;
                if (keep) begin
                    wr_ptr_reg <= wr_ptr_reg + appt_pkg::cnt_t'(1);
                end else begin
                    count_reg <= count_reg - appt_pkg::cnt_t'(1);
                end
                if (match && !is_tick) begin
                    found_reg <= 1'b1;
                end
                if (step_emits) begin
                    pend_valid_reg <= 1'b1;
                    pend_addr_reg  <= rd_addr_reg;
                    pend_count_reg <= count_reg - appt_pkg::cnt_t'(1);
                end
            end
            if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
                if (is_heard && !found_reg
                    && (count_reg < appt_pkg::cnt_t'(appt_pkg::TABLE_DEPTH))) begin
                    count_reg <= count_reg + appt_pkg::cnt_t'(1);
                end
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_code_reg  <= push_code;
            out_addr_reg  <= push_addr;
            out_count_reg <= appt_pkg::entry_t'(push_count);
            out_last_reg  <= push_last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_event_code    = out_code_reg;
    assign out_event_address = out_addr_reg;
    assign out_entry_count   = out_count_reg;
    assign out_last          = out_last_reg;

    `APPT_ALWAYS(a_count_range, count_reg <= appt_pkg::cnt_t'(appt_pkg::TABLE_DEPTH), "count above depth")
    `APPT_ALWAYS(a_wr_behind_rd, wr_ptr_reg <= idx_reg, "write pointer ahead of scan")
    `APPT_IMPLIES(a_pend_tick, pend_valid_reg, is_tick, "pending expiry outside a tick")

endmodule

>>> design/appt_ctrl.sv
// sequencer for accept, table scan and result of one item
// depends on appt_pkg
module appt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  appt_pkg::ctrl_status_t status,
    output appt_pkg::ctrl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && !status.req_none) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FINISH;
                end else if (!status.step_blocked) begin
                    cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!status.finish_blocked) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/aging_peer_presence_table.sv
// top level: an item runs from accept through the table scan to its last
// result in the output register, one table entry per cycle unless the output stalls
// next item accepted the cycle after that result is loaded; output stalls can hold the scan
// unused request type 3 is accepted and dropped with no result
// synchronous active-low reset empties the table and loads a timeout of 9000
module aging_peer_presence_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // peer_address
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // event_address, entry_count, zero pad
    output logic [2:0]  m_tuser,   // event_code
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // timeout_ticks
);

    appt_pkg::ctrl_cmd_t    cmd;
    appt_pkg::ctrl_status_t status;
    appt_pkg::addr_t        event_address;
    appt_pkg::entry_t       entry_count;

    assign cfg_ready = 1'b1;

    appt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    appt_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .req_type          (s_tuser),
        .peer_address      (s_tdata),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_event_code    (m_tuser),
        .out_event_address (event_address),
        .out_entry_count   (entry_count),
        .out_last          (m_tlast)
    );

    assign m_tdata = {3'b000, entry_count, event_address};

endmodule
